// File: rtl/core/pfr_pkg.sv
// Package for the Pareto front ranker: controller states, command/status structs,
// objective width and payload types. No dependencies.
package pfr_pkg;

    localparam int OBJ_WIDTH = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DOM,
        ST_SCAN,
        ST_PEEL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_en;      // write incoming point
        logic dom_start;    // clear pair counters, ranked set and level
        logic dom_step;     // evaluate one (p,q) pair
        logic scan_start;   // clear scan index and front
        logic scan_step;    // test one point for the front
        logic front_commit; // fold front into ranked set, next front
        logic emit_start;   // clear emit index
        logic emit_step;    // advance emit index
        logic set_done;     // clear point count
    } cmd_t;

    typedef struct packed {
        logic full;
        logic dom_last;
        logic scan_last;
        logic front_empty;
        logic emit_last;
    } status_t;

    typedef struct packed {
        logic [OBJ_WIDTH-1:0] objective_a;
        logic [OBJ_WIDTH-1:0] objective_b;
        logic                 final_point;
    } in_item_t;

    typedef struct packed {
        logic [5:0] point_index;
        logic [5:0] front_rank;
        logic       final_result;
    } out_item_t;

endpackage

// File: rtl/core/pfr_ctrl.sv
// Controller state machine for the Pareto front ranker.
// Depends on pfr_pkg.
module pfr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_final,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  pfr_pkg::status_t   status,
    output pfr_pkg::cmd_t      cmd
);

    pfr_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pfr_pkg::ST_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            pfr_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_en = !status.full;
                    if (in_final)
                    begin
                        cmd.dom_start = 1'b1;
                        state_next    = pfr_pkg::ST_DOM;
                    end
                end
            end
            pfr_pkg::ST_DOM:
            begin
                cmd.dom_step = 1'b1;
                if (status.dom_last)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = pfr_pkg::ST_SCAN;
                end
            end
            pfr_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = pfr_pkg::ST_PEEL;
            end
            pfr_pkg::ST_PEEL:
            begin
                if (status.front_empty)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = pfr_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.front_commit = 1'b1;
                    cmd.scan_start   = 1'b1;
                    state_next       = pfr_pkg::ST_SCAN;
                end
            end
            pfr_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.emit_step = 1'b1;
                    if (status.emit_last)
                    begin
                        cmd.set_done = 1'b1;
                        state_next   = pfr_pkg::ST_LOAD;
                    end
                end
            end
            default:
                state_next = pfr_pkg::ST_LOAD;
        endcase
    end

endmodule

// File: rtl/core/pfr_datapath.sv
// Datapath for the Pareto front ranker: point store, dominator rows, front and ranks.
// Depends on pfr_pkg.
module pfr_datapath #(
    parameter int MAX_POINTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pfr_pkg::in_item_t   in_item,
    input  pfr_pkg::cmd_t       cmd,
    output pfr_pkg::status_t    status,
    output pfr_pkg::out_item_t  out_item
);

    localparam int OW = pfr_pkg::OBJ_WIDTH;
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    // objective keys: sign bit flipped so unsigned compare orders them
    logic [OW-1:0] key_a_mem [MAX_POINTS];
    logic [OW-1:0] key_b_mem [MAX_POINTS];
    // entry p has bit q set when q dominates p
    logic [MAX_POINTS-1:0] dom_by_mem [MAX_POINTS];
    logic [5:0]    rank_mem [MAX_POINTS];

    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] p_reg, p_next, q_reg, q_next, e_reg, e_next;
    logic [MAX_POINTS-1:0] ranked_reg, ranked_next, front_reg, front_next;
    logic [5:0]    level_reg, level_next;
    logic [MAX_POINTS-1:0] row_acc_reg, row_acc_next;

    logic [OW-1:0] pa_reg, pb_reg, qa_reg, qb_reg;
    logic [MAX_POINTS-1:0] dom_by_reg;
    logic [5:0]    rank_reg;

    logic [OW-1:0] new_a, new_b;
    logic dom_qp;
    logic [MAX_POINTS-1:0] row_full;
    logic row_wr;
    logic is_front;
    logic [IW-1:0] n_last;

    assign new_a = {~in_item.objective_a[OW-1], in_item.objective_a[OW-2:0]};
    assign new_b = {~in_item.objective_b[OW-1], in_item.objective_b[OW-2:0]};

    // index of the last point, counting a possible final load
    assign n_last = IW'(count_reg - CW'(1));

    assign dom_qp = (p_reg != q_reg) && (qa_reg <= pa_reg) && (qb_reg <= pb_reg) &&
                    ((qa_reg < pa_reg) || (qb_reg < pb_reg));
    assign row_full = row_acc_reg | (MAX_POINTS'(dom_qp) << q_reg);
    assign row_wr   = cmd.dom_step && (q_reg == n_last);

    // in the front when unranked and every dominator is already ranked
    assign is_front = !ranked_reg[p_reg] && ((dom_by_reg & ~ranked_reg) == '0);

    assign status.full        = (count_reg == CW'(MAX_POINTS));
    assign status.dom_last    = (p_reg == n_last) && (q_reg == n_last);
    assign status.scan_last   = (p_reg == n_last);
    assign status.front_empty = (front_reg == '0);
    assign status.emit_last   = (e_reg == n_last);

    assign out_item.point_index  = 6'(e_reg);
    assign out_item.front_rank   = rank_reg;
    assign out_item.final_result = (e_reg == n_last);

    always_comb
    begin
        count_next   = count_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        e_next       = e_reg;
        ranked_next  = ranked_reg;
        front_next   = front_reg;
        level_next   = level_reg;
        row_acc_next = row_acc_reg;
        if (cmd.load_en)
            count_next = count_reg + CW'(1);
        if (cmd.set_done)
            count_next = '0;
        if (cmd.dom_start)
        begin
            p_next       = '0;
            q_next       = '0;
            row_acc_next = '0;
            ranked_next  = '0;
            level_next   = '0;
        end
        if (cmd.dom_step)
        begin
            if (q_reg == n_last)
            begin
                q_next       = '0;
                p_next       = p_reg + IW'(1);
                row_acc_next = '0;
            end
            else
            begin
                q_next       = q_reg + IW'(1);
                row_acc_next = row_full;
            end
        end
        if (cmd.scan_step)
        begin
            if (is_front)
                front_next[p_reg] = 1'b1;
            p_next = p_reg + IW'(1);
        end
        if (cmd.scan_start)
        begin
            p_next     = '0;
            front_next = '0;
        end
        if (cmd.front_commit)
        begin
            ranked_next = ranked_reg | front_reg;
            level_next  = level_reg + 6'd1;
        end
        if (cmd.emit_start)
            e_next = '0;
        if (cmd.emit_step)
            e_next = e_reg + IW'(1);
    end

    // read registers follow the next index, so each holds the entry at the current one
    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
        begin
            key_a_mem[count_reg[IW-1:0]] <= new_a;
            key_b_mem[count_reg[IW-1:0]] <= new_b;
        end
        if (row_wr)
            dom_by_mem[p_reg] <= row_full;
        if (cmd.scan_step && is_front)
            rank_mem[p_reg] <= level_level_guard(level_reg);
        // a stale key on the final load only reaches the self pair, which is masked
        pa_reg <= key_a_mem[p_next];
        pb_reg <= key_b_mem[p_next];
        qa_reg <= key_a_mem[q_next];
        qb_reg <= key_b_mem[q_next];
        // forward a row written on the same edge
        if (row_wr && (p_reg == p_next))
            dom_by_reg <= row_full;
        else
            dom_by_reg <= dom_by_mem[p_next];
        rank_reg <= rank_mem[e_next];
    end

    function automatic logic [5:0] level_level_guard(logic [5:0] lvl);
        return lvl;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            p_reg       <= '0;
            q_reg       <= '0;
            e_reg       <= '0;
            ranked_reg  <= '0;
            front_reg   <= '0;
            level_reg   <= '0;
            row_acc_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            p_reg       <= p_next;
            q_reg       <= q_next;
            e_reg       <= e_next;
            ranked_reg  <= ranked_next;
            front_reg   <= front_next;
            level_reg   <= level_next;
            row_acc_reg <= row_acc_next;
        end
    end

endmodule

// File: rtl/core/pareto_front_ranker_unit.sv
// Pareto front ranker: loads up to MAX_POINTS points at one transaction per cycle and
// drops points beyond capacity, then ranks them into non-dominated fronts. After the
// final point the dominance pass checks one pair per cycle through a single
// comparator. Each front then takes a scan of all points and a peel step that folds
// it into the ranked set, and a last scan that finds no front ends the ranking.
// Results then stream at up to one per cycle, one per point in load order; no input
// is taken until the last one is accepted.
// Depends on pfr_pkg, pfr_ctrl and pfr_datapath.
module pareto_front_ranker_unit #(
    parameter int MAX_POINTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfr_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pfr_pkg::out_item_t  out_data
);

    pfr_pkg::cmd_t    cmd;
    pfr_pkg::status_t status;

    pfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_final  (in_data.final_point),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pfr_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_data)
    );

endmodule

// File: rtl/core/pfr_checker.sv
// Port-level checker for the Pareto front ranker, bound to the top level.
// Depends on pfr_pkg.
module pfr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input pfr_pkg::out_item_t out_data
);

    // no input taken while results stream
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input accepted during output");

    // indices step by one within a set
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.final_result) |=>
            (out_data.point_index == $past(out_data.point_index) + 6'd1))
        else $error("point index skipped");

    // a set begins at index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (out_data.point_index == 6'd0))
        else $error("set did not start at zero");

    // after the last transaction the block returns to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.final_result) |=> in_ready)
        else $error("not ready after set");

endmodule

bind pareto_front_ranker_unit pfr_checker u_pfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
